/* hdl/brb_pkg.sv */
// Shared types and constants of the byte ring buffer deque.
package brb_pkg;

   localparam int CMD_W         = 3;
   localparam int DATA_W        = 8;
   localparam int CNT_W         = 5;
   localparam int FILL_W        = 9;
   localparam int DEPTH_DEF     = 256;
   localparam int MAX_BURST_DEF = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_LOSSLESS  = 3'd0,
      CMD_WR_OVERWRITE = 3'd1,
      CMD_READ         = 3'd2,
      CMD_PEEK         = 3'd3,
      CMD_RREAD        = 3'd4,
      CMD_RPEEK        = 3'd5
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_BURST
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              has_byte;
      logic              accepted;
      logic [FILL_W-1:0] fill_level;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } push_type;

   typedef struct packed {
      logic [1:0] level;
      logic       pop;
   } qstat_type;

endpackage

/* hdl/brb_if.sv */
// Channel interfaces for commands and results.
interface brb_req_if;
   logic                        valid;
   logic                        ready;
   logic [brb_pkg::CMD_W-1:0]   command;
   logic [brb_pkg::DATA_W-1:0]  data_byte;
   logic [brb_pkg::CNT_W-1:0]   count;

   modport source (output valid, command, data_byte, count, input ready);
   modport sink   (input valid, command, data_byte, count, output ready);
endinterface

interface brb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [brb_pkg::DATA_W-1:0]  out_byte;
   logic                        has_byte;
   logic                        accepted;
   logic [brb_pkg::FILL_W-1:0]  fill_level;
   logic                        last;

   modport source (output valid, out_byte, has_byte, accepted, fill_level, last,
                   input ready);
   modport sink   (input valid, out_byte, has_byte, accepted, fill_level, last,
                   output ready);
endinterface

/* hdl/brb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/brb_rsp_fifo.sv */
// Two-entry result queue between the command control and the result channel.
module brb_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  brb_pkg::push_type   push,
   brb_rsp_if.source           rsp,
   output brb_pkg::qstat_type  qstat
);

   brb_pkg::rsp_type slot_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       level_ff, level_in;
   logic             pop;
   brb_pkg::rsp_type head;

   assign head           = slot_ff[rd_ff];
   assign rsp.valid      = (level_ff != 2'd0);
   assign rsp.out_byte   = head.out_byte;
   assign rsp.has_byte   = head.has_byte;
   assign rsp.accepted   = head.accepted;
   assign rsp.fill_level = head.fill_level;
   assign rsp.last       = head.last;
   assign pop            = rsp.valid && rsp.ready;

   assign qstat.level = level_ff;
   assign qstat.pop   = pop;

   always_comb begin
      wr_in    = push.valid ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      level_in = level_ff + 2'(push.valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         level_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ff] <= push.item;
      end
   end

endmodule

/* hdl/brb_ctrl.sv */
// Command control: pointers, fill count, write path and read burst sequencer.
module brb_ctrl #(
   parameter int DEPTH     = brb_pkg::DEPTH_DEF,
   parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   brb_req_if.sink                   req,
   input  logic                      csr_we,
   input  logic [brb_pkg::FILL_W-1:0] csr_wdata,
   input  brb_pkg::qstat_type        qstat,
   output brb_pkg::push_type         push,
   output logic                      ram_we,
   output logic [$clog2(DEPTH)-1:0]  ram_waddr,
   output logic [brb_pkg::DATA_W-1:0] ram_wdata,
   output logic [$clog2(DEPTH)-1:0]  ram_raddr,
   input  logic [brb_pkg::DATA_W-1:0] ram_rdata
);

   localparam int FW = brb_pkg::FILL_W;
   localparam int PW = $clog2(DEPTH);
   localparam int SW = ((PW > FW) ? PW : FW) + 1;
   localparam int BW = $clog2(MAX_BURST + 1);
   localparam logic [FW-1:0] CAP_RST = FW'((DEPTH > 511) ? 511 : DEPTH);

   brb_pkg::state_type state_ff, state_in;
   logic [FW-1:0] cap_ff, cap_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [PW-1:0] addr_ff, addr_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [FW-1:0] fout_ff, fout_in;
   logic          pend_ff, pend_in;
   logic          plast_ff, plast_in;

   logic [FW-1:0] c_eff;
   logic [SW-1:0] c_x, n_x;
   logic [SW-1:0] wp_sum, rp_sum, addr_sum;
   logic [PW-1:0] wp_inc, rp_adv, addr_inc, rstart;
   logic [FW:0]   fill_p1;
   logic [FW-1:0] n_req, n;
   logic [2:0]    occ;
   logic          accept;

   // Effective capacity: zero reads as one, anything past the store as its depth.
   always_comb begin
      if (cap_ff == '0) begin
         c_eff = FW'(1);
      end else if (32'(cap_ff) > DEPTH) begin
         c_eff = FW'(DEPTH);
      end else begin
         c_eff = cap_ff;
      end
   end

   always_comb begin
      c_x      = SW'(c_eff);
      n_req    = (FW'(req.count) > FW'(MAX_BURST)) ? FW'(MAX_BURST) : FW'(req.count);
      n        = (n_req > fill_ff) ? fill_ff : n_req;
      n_x      = SW'(n);
      fill_p1  = {1'b0, fill_ff} + (FW+1)'(1);
      wp_sum   = SW'(wp_ff) + SW'(1);
      wp_inc   = (wp_sum >= c_x) ? PW'(wp_sum - c_x) : PW'(wp_sum);
      rp_sum   = SW'(rp_ff) + n_x;
      rp_adv   = (rp_sum >= c_x) ? PW'(rp_sum - c_x) : PW'(rp_sum);
      addr_sum = SW'(addr_ff) + SW'(1);
      addr_inc = (addr_sum >= c_x) ? PW'(addr_sum - c_x) : PW'(addr_sum);
      rstart   = (SW'(wp_ff) >= n_x) ? PW'(SW'(wp_ff) - n_x)
                                     : PW'(SW'(wp_ff) + c_x - n_x);
      occ      = 3'(qstat.level) + 3'(pend_ff);
   end

   assign req.ready = (state_ff == brb_pkg::ST_IDLE) && !pend_ff
                      && ((qstat.level != 2'd2) || qstat.pop);
   assign accept    = req.valid && req.ready;
   assign ram_waddr = wp_ff;
   assign ram_wdata = req.data_byte;
   assign ram_raddr = addr_ff;

   always_comb begin
      state_in = state_ff;
      cap_in   = cap_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      fill_in  = fill_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      fout_in  = fout_ff;
      pend_in  = 1'b0;
      plast_in = plast_ff;
      ram_we   = 1'b0;
      push     = '0;

      if (csr_we) begin
         // new capacity empties the queue; stored bytes stay
         cap_in  = csr_wdata;
         wp_in   = '0;
         rp_in   = '0;
         fill_in = '0;
      end else if (accept) begin
         push.valid     = 1'b1;
         push.item.last = 1'b1;
         case (brb_pkg::cmd_type'(req.command))
            brb_pkg::CMD_WR_LOSSLESS: begin
               if (fill_ff < c_eff) begin
                  ram_we             = 1'b1;
                  wp_in              = wp_inc;
                  fill_in            = fill_p1[FW-1:0];
                  push.item.accepted = 1'b1;
               end
            end
            brb_pkg::CMD_WR_OVERWRITE: begin
               ram_we             = 1'b1;
               wp_in              = wp_inc;
               push.item.accepted = 1'b1;
               if (fill_p1 >= {1'b0, c_eff}) begin
                  // full: drop the oldest byte
                  fill_in = c_eff;
                  rp_in   = wp_inc;
               end else begin
                  fill_in = fill_p1[FW-1:0];
               end
            end
            brb_pkg::CMD_READ, brb_pkg::CMD_PEEK,
            brb_pkg::CMD_RREAD, brb_pkg::CMD_RPEEK: begin
               if (n != '0) begin
                  push.valid = 1'b0;
                  state_in   = brb_pkg::ST_BURST;
                  rem_in     = BW'(n);
                  addr_in    = rp_ff;
                  if ((brb_pkg::cmd_type'(req.command) == brb_pkg::CMD_RREAD)
                      || (brb_pkg::cmd_type'(req.command) == brb_pkg::CMD_RPEEK)) begin
                     addr_in = rstart;
                  end
                  if (brb_pkg::cmd_type'(req.command) == brb_pkg::CMD_READ) begin
                     rp_in   = rp_adv;
                     fill_in = fill_ff - n;
                  end else if (brb_pkg::cmd_type'(req.command) == brb_pkg::CMD_RREAD) begin
                     wp_in   = rstart;
                     fill_in = fill_ff - n;
                  end
                  fout_in = fill_in;
               end
            end
            default: begin
            end
         endcase
         push.item.fill_level = fill_in;
      end else if (state_ff == brb_pkg::ST_BURST) begin
         // issue a read only when its data will find a free queue slot
         if (occ <= 3'd1 + 3'(qstat.pop)) begin
            addr_in  = addr_inc;
            rem_in   = rem_ff - BW'(1);
            pend_in  = 1'b1;
            plast_in = (rem_ff == BW'(1));
            if (rem_ff == BW'(1)) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
      end

      if (pend_ff) begin
         push.valid           = 1'b1;
         push.item.out_byte   = ram_rdata;
         push.item.has_byte   = 1'b1;
         push.item.accepted   = 1'b0;
         push.item.fill_level = fout_ff;
         push.item.last       = plast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brb_pkg::ST_IDLE;
         cap_ff   <= CAP_RST;
         wp_ff    <= '0;
         rp_ff    <= '0;
         fill_ff  <= '0;
         rem_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         fill_ff  <= fill_in;
         rem_ff   <= rem_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      fout_ff  <= fout_in;
      plast_ff <= plast_in;
   end

endmodule

/* hdl/byte_ring_buffer_deque.sv */
// Byte ring buffer deque: lossless and overwriting writes, reads and peeks
// from the oldest end, reverse reads and peeks from the newest end. The
// bytes live in one DEPTH-entry RAM with a registered read port; pointers
// and the fill count sit in registers. A write, or a command with nothing to
// return, is done once it is taken and its result lands in a two-entry output
// queue, so the next command is taken while one result still waits. A read
// command that returns n bytes (n at most MAX_BURST and at most the fill
// level) runs in steps: the command is taken, the RAM read port is given one
// address per byte, and the last byte comes back; under back pressure the
// burst waits for queue space. A capacity write empties the queue at once
// and keeps the stored bytes; there is no clearing pass after reset.
module byte_ring_buffer_deque #(
   parameter int DEPTH     = brb_pkg::DEPTH_DEF,
   parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   brb_req_if.sink                    req_ch,
   brb_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [brb_pkg::FILL_W-1:0] csr_wdata
);

   localparam int PW = $clog2(DEPTH);

   brb_pkg::push_type           push;
   brb_pkg::qstat_type          qstat;
   logic                        ram_we;
   logic [PW-1:0]               ram_waddr;
   logic [brb_pkg::DATA_W-1:0]  ram_wdata;
   logic [PW-1:0]               ram_raddr;
   logic [brb_pkg::DATA_W-1:0]  ram_rdata;

   brb_ctrl #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .push      (push),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   brb_ram #(
      .WIDTH (brb_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   brb_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .rsp   (rsp_ch),
      .qstat (qstat)
   );

   // a result never lands on a full queue that is not draining
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> ((qstat.level != 2'd2) || qstat.pop))
      else $error("result pushed into full output queue");

   // the store is written only by an accepted command transfer
   a_write_on_transfer: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (req_ch.valid && req_ch.ready))
      else $error("store written without a command transfer");

   // no command is taken while burst data is still on its way back
   a_hold_during_burst: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.item.has_byte && !push.item.last) |-> !req_ch.ready)
      else $error("command taken in the middle of a read burst");

endmodule

/* test/brb_ring_mirror.sv */
// Mirror of the byte ring: tracks commands and capacity writes, predicts and checks results.
module brb_ring_mirror (
   input  logic                       clock,
   input  logic                       reset,
   brb_req_if                         req_mon,
   brb_rsp_if                         rsp_mon,
   input  logic                       csr_we,
   input  logic [brb_pkg::FILL_W-1:0] csr_wdata,
   output int                         pending,
   output int                         fails,
   output int                         checked
);
   import brb_pkg::*;

   localparam int unsigned RING_SLOTS = DEPTH_DEF;
   localparam int unsigned BURST_MAX  = MAX_BURST_DEF;

   logic [DATA_W-1:0] ring [RING_SLOTS];
   int unsigned       wr_ptr;
   int unsigned       rd_ptr;
   logic              ring_full;
   logic [FILL_W-1:0] cap_reg;
   rsp_type           rsp_owed [$];
   int                fail_cnt  = 0;
   int                check_cnt = 0;

   function automatic int unsigned slots_in_use();
      if (cap_reg == 0) return 1;
      if (cap_reg > RING_SLOTS) return RING_SLOTS;
      return cap_reg;
   endfunction

   function automatic int unsigned bytes_held();
      int unsigned c;
      c = slots_in_use();
      if (wr_ptr > rd_ptr) return wr_ptr - rd_ptr;
      if (wr_ptr < rd_ptr) return c - (rd_ptr - wr_ptr);
      return ring_full ? c : 0;
   endfunction

   function automatic void owe(logic [DATA_W-1:0] b, logic hb, logic acc, int unsigned fill,
                               logic lst);
      rsp_type r;
      r.out_byte   = b;
      r.has_byte   = hb;
      r.accepted   = acc;
      r.fill_level = FILL_W'(fill);
      r.last       = lst;
      rsp_owed.push_back(r);
   endfunction

   function automatic void run_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                                       logic [CNT_W-1:0] cnt);
      int unsigned c;
      int unsigned used;
      int unsigned n;
      int unsigned first;
      int unsigned fill;
      logic        acc;
      c    = slots_in_use();
      used = bytes_held();
      wr_ptr = wr_ptr % c;
      rd_ptr = rd_ptr % c;
      case (cmd)
         CMD_WR_LOSSLESS: begin
            acc = 1'b0;
            if (used < c) begin
               ring[wr_ptr] = data;
               wr_ptr = (wr_ptr + 1) % c;
               if (wr_ptr == rd_ptr) ring_full = 1'b1;
               acc = 1'b1;
            end
            owe('0, 1'b0, acc, bytes_held(), 1'b1);
         end
         CMD_WR_OVERWRITE: begin
            ring[wr_ptr] = data;
            wr_ptr = (wr_ptr + 1) % c;
            // mark the ring full once this write fills it, dropping the oldest byte when it was already full
            if (used + 1 >= c) begin
               ring_full = 1'b1;
               rd_ptr    = wr_ptr;
            end
            owe('0, 1'b0, 1'b1, bytes_held(), 1'b1);
         end
         CMD_READ, CMD_PEEK, CMD_RREAD, CMD_RPEEK: begin
            n = cnt;
            if (n > BURST_MAX) n = BURST_MAX;
            if (n > used) n = used;
            if (n == 0) begin
               owe('0, 1'b0, 1'b0, used, 1'b1);
            end else begin
               if (cmd == CMD_READ || cmd == CMD_PEEK) first = rd_ptr;
               else first = (wr_ptr + c - n) % c;
               if (cmd == CMD_READ) begin
                  rd_ptr    = (rd_ptr + n) % c;
                  ring_full = 1'b0;
               end else if (cmd == CMD_RREAD) begin
                  wr_ptr    = first;
                  ring_full = 1'b0;
               end
               // removal leaves the ring contents alone, so read them afterwards
               fill = bytes_held();
               for (int unsigned i = 0; i < n; i++)
                  owe(ring[(first + i) % c], 1'b1, 1'b0, fill, i + 1 == n);
            end
         end
         default: owe('0, 1'b0, 1'b0, used, 1'b1);
      endcase
   endfunction

   task automatic flag_field(string name, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_cnt++;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_owed.delete();
         wr_ptr    = 0;
         rd_ptr    = 0;
         ring_full = 1'b0;
         cap_reg   = FILL_W'(RING_SLOTS);
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.out_byte   = rsp_mon.out_byte;
            got.has_byte   = rsp_mon.has_byte;
            got.accepted   = rsp_mon.accepted;
            got.fill_level = rsp_mon.fill_level;
            got.last       = rsp_mon.last;
            if (rsp_owed.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %0h", $time, got);
               fail_cnt++;
            end else begin
               want = rsp_owed.pop_front();
               check_cnt++;
               if (got.out_byte !== want.out_byte)
                  flag_field("out_byte", want.out_byte, got.out_byte);
               if (got.has_byte !== want.has_byte)
                  flag_field("has_byte", want.has_byte, got.has_byte);
               if (got.accepted !== want.accepted)
                  flag_field("accepted", want.accepted, got.accepted);
               if (got.fill_level !== want.fill_level)
                  flag_field("fill_level", want.fill_level, got.fill_level);
               if (got.last !== want.last)
                  flag_field("last", want.last, got.last);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            run_command(req_mon.command, req_mon.data_byte, req_mon.count);
         // a capacity write empties the ring but keeps the bytes
         if (csr_we === 1'b1) begin
            cap_reg   = csr_wdata;
            wr_ptr    = 0;
            rd_ptr    = 0;
            ring_full = 1'b0;
         end
      end
      pending <= rsp_owed.size();
      fails   <= fail_cnt;
      checked <= check_cnt;
   end

endmodule

/* test/testbench.sv */
// Top of the ring buffer deque test: clock, reset, command stimulus, result back pressure, verdict.
module testbench;
   import brb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
   localparam int CYCLE_LIMIT = 600000;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [FILL_W-1:0] csr_wdata;
   int                pending;
   int                fails;
   int                checked;
   int                cycles     = 0;
   int                sent       = 0;
   int                cap_writes = 0;
   bit                tx_steady  = 0;
   bit                rx_steady  = 0;

   brb_req_if req_ch ();
   brb_rsp_if rsp_ch ();

   byte_ring_buffer_deque uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   brb_ring_mirror mirror (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .fails     (fails),
      .checked   (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // mostly short idle stretches, a few long ones
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back pressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = idle_len();
         end
      end
   end

   task automatic send(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data, logic [CNT_W-1:0] cnt);
      int gap;
      gap = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.data_byte <= data;
      req_ch.count     <= cnt;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent++;
   endtask

   // hold the sender until every predicted result has been taken
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(logic [FILL_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_writes++;
   endtask

   task automatic random_item(bit filling);
      int               r;
      logic [CMD_W-1:0] cmd;
      logic [CNT_W-1:0] cnt;
      r = $urandom_range(0, 99);
      if (r < 5) cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
      else if ((r < 75) == filling)
         cmd = $urandom_range(0, 1) ? CMD_WR_OVERWRITE : CMD_WR_LOSSLESS;
      else cmd = CMD_W'($urandom_range(CMD_READ, CMD_RPEEK));
      r = $urandom_range(0, 99);
      if (r < 5) cnt = '0;
      else if (r < 20) cnt = CNT_W'($urandom_range(17, 31));
      else cnt = CNT_W'($urandom_range(1, 16));
      send(cmd, DATA_W'($urandom_range(0, 255)), cnt);
   endtask

   initial begin
      logic [FILL_W-1:0] cap;
      bit                filling;
      int                left;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_WR_LOSSLESS;
      req_ch.data_byte <= '0;
      req_ch.count     <= '0;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty ring, then a few bytes at the default capacity
      send(CMD_READ, 8'h00, 5'd4);
      send(CMD_RPEEK, 8'hFF, 5'd1);
      send(CMD_WR_LOSSLESS, 8'h00, 5'd0);
      send(CMD_WR_LOSSLESS, 8'hFF, 5'd31);
      send(CMD_WR_OVERWRITE, 8'hA5, 5'd0);
      send(CMD_PEEK, 8'h00, 5'd0);
      send(CMD_PEEK, 8'h00, 5'd31);
      send(CMD_RPEEK, 8'h00, 5'd2);
      send(CMD_RREAD, 8'h00, 5'd1);
      send(CMD_READ, 8'h00, 5'd1);
      send(CMD_SPARE6, 8'hFF, 5'd31);
      send(CMD_SPARE7, 8'h00, 5'd1);
      send(CMD_READ, 8'h00, 5'd16);
      // zero capacity acts as a single slot
      set_capacity(9'd0);
      send(CMD_WR_LOSSLESS, 8'h11, 5'd1);
      send(CMD_WR_LOSSLESS, 8'h22, 5'd1);
      send(CMD_WR_OVERWRITE, 8'h33, 5'd1);
      send(CMD_RREAD, 8'h00, 5'd5);
      set_capacity(9'd2);
      send(CMD_WR_OVERWRITE, 8'h01, 5'd0);
      send(CMD_WR_OVERWRITE, 8'h02, 5'd0);
      send(CMD_WR_OVERWRITE, 8'h03, 5'd0);
      send(CMD_PEEK, 8'h00, 5'd2);
      send(CMD_RPEEK, 8'h00, 5'd1);
      send(CMD_RREAD, 8'h00, 5'd2);
      send(CMD_READ, 8'h00, 5'd1);

      // random phases: alternate fill and drain bursts at each capacity
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       cap = 9'd5;
            1:       cap = 9'd1;
            2:       cap = 9'd16;
            3:       cap = 9'd256;
            4:       cap = 9'd2;
            5:       cap = 9'd0;
            6:       cap = FILL_W'($urandom_range(17, 40));
            default: cap = 9'd511;
         endcase
         set_capacity(cap);
         tx_steady = (ph % 3 == 2);
         rx_steady = (ph % 4 == 1);
         filling   = 1'b1;
         left      = $urandom_range(6, 20);
         for (int i = 0; i < 23; i++) begin
            if (left == 0) begin
               filling = !filling;
               left    = $urandom_range(3, 14);
            end
            left--;
            if (i == 11) settle();
            random_item(filling);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      $display("Sent %0d commands over %0d capacity writes (0, 1, 2, 256 and 511 among them);",
               sent, cap_writes);
      $display("checked %0d results covering overwrite drops, bursts and reverse reads.",
               checked);
      if (fails == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule

/* byte_ring_buffer_deque.f */
hdl/brb_pkg.sv
hdl/brb_if.sv
hdl/brb_ram.sv
hdl/brb_rsp_fifo.sv
hdl/brb_ctrl.sv
hdl/byte_ring_buffer_deque.sv
test/brb_ring_mirror.sv
test/testbench.sv
